// ----- hw/rtl/pfts_pkg.sv -----
// ----------------------------------------------------------------------------
// pfts_pkg
// Shared types and constants of the priority FIFO task scheduler.
// ----------------------------------------------------------------------------
package pfts_pkg;

	localparam int ID_W   = 6;
	localparam int ID_CNT = 1 << ID_W;
	localparam int PRIO_W = 8;

	localparam logic OP_ENQUEUE  = 1'b0;
	localparam logic OP_GET_NEXT = 1'b1;

	typedef enum logic {
		ST_IDLE,
		ST_HEAD_WB
	} sched_state_t;

	typedef struct packed {
		logic head_we;
		logic tail_we;
		logic ne_set;
		logic ne_clr;
	} lvl_ctl_t;

endpackage

// ----- hw/rtl/pfts_req_if.sv -----
// ----------------------------------------------------------------------------
// pfts_req_if
// Request channel: enqueue or get-next beats into the scheduler.
// ----------------------------------------------------------------------------
interface pfts_req_if import pfts_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     opcode;
	logic [ID_W-1:0]          task_id;
	logic signed [PRIO_W-1:0] task_priority;
	logic                     current_valid;
	logic                     current_running;
	logic [ID_W-1:0]          current_id;
	logic signed [PRIO_W-1:0] current_priority;

	modport source (
		output valid, opcode, task_id, task_priority,
		output current_valid, current_running, current_id, current_priority,
		input  ready
	);
	modport sink (
		input  valid, opcode, task_id, task_priority,
		input  current_valid, current_running, current_id, current_priority,
		output ready
	);
endinterface

// ----- hw/rtl/pfts_rsp_if.sv -----
// ----------------------------------------------------------------------------
// pfts_rsp_if
// Response channel: one result beat per request.
// ----------------------------------------------------------------------------
interface pfts_rsp_if import pfts_pkg::*; ();
	logic            valid;
	logic            ready;
	logic            next_valid;
	logic [ID_W-1:0] next_id;
	logic            kept_current;
	logic            reset_slice;

	modport source (
		output valid, next_valid, next_id, kept_current, reset_slice,
		input  ready
	);
	modport sink (
		input  valid, next_valid, next_id, kept_current, reset_slice,
		output ready
	);
endinterface

// ----- hw/rtl/pfts_link_ram.sv -----
// ----------------------------------------------------------------------------
// pfts_link_ram
// Successor links of queued tasks: one write port, one registered read port.
// ----------------------------------------------------------------------------
module pfts_link_ram import pfts_pkg::*; #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [AW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [AW-1:0] rdata
);

	logic [AW-1:0] mem_q [DEPTH];
	logic [AW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- hw/rtl/pfts_lvl_tbl.sv -----
// ----------------------------------------------------------------------------
// pfts_lvl_tbl
// Per-level head, tail and nonempty flags, plus the highest-nonempty encoder.
// ----------------------------------------------------------------------------
module pfts_lvl_tbl import pfts_pkg::*; #(
	parameter int LEVELS = 8,
	parameter int LVL_W  = 3,
	parameter int IDX_W  = 6
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [LVL_W-1:0] lvl,
	input  lvl_ctl_t         ctl,
	input  logic [IDX_W-1:0] head_wdata,
	input  logic [IDX_W-1:0] tail_wdata,
	output logic [IDX_W-1:0] head_rd,
	output logic [IDX_W-1:0] tail_rd,
	output logic             lvl_ne,
	output logic             any_ne,
	output logic [LVL_W-1:0] hi_lvl
);

	logic [IDX_W-1:0] head_q [LEVELS];
	logic [IDX_W-1:0] tail_q [LEVELS];
	logic [LEVELS-1:0] ne_q;

	always_ff @(posedge clk) begin
		if (ctl.head_we) begin
			head_q[lvl] <= head_wdata;
		end
		if (ctl.tail_we) begin
			tail_q[lvl] <= tail_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ne_q <= '0;
		end else if (ctl.ne_set) begin
			ne_q[lvl] <= 1'b1;
		end else if (ctl.ne_clr) begin
			ne_q[lvl] <= 1'b0;
		end
	end

	assign head_rd = head_q[lvl];
	assign tail_rd = tail_q[lvl];
	assign lvl_ne  = ne_q[lvl];
	assign any_ne  = |ne_q;

	always_comb begin
		hi_lvl = '0;
		for (int i = 0; i < LEVELS; i++) begin
			if (ne_q[i]) begin
				hi_lvl = LVL_W'(i);
			end
		end
	end

endmodule

// ----- hw/rtl/priority_fifo_task_scheduler.sv -----
// ----------------------------------------------------------------------------
// priority_fifo_task_scheduler
// Eight-level FCFS ready queues over task ids, with enqueue and get-next.
// ----------------------------------------------------------------------------
// An enqueue is applied when it is accepted, as is a get-next that keeps the
// current task, finds nothing, or pops the last task of a level. When the
// popped level holds more tasks, the successor link is read from the link
// memory and written back as the new head in the next cycle.
// Each request yields exactly one response beat, held in an output register;
// a new request is taken once the previous one has finished its write-back
// and the output register is free or being drained in the same cycle.
// ----------------------------------------------------------------------------
module priority_fifo_task_scheduler import pfts_pkg::*; #(
	parameter int LEVELS    = 8,
	parameter int MAX_TASKS = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	pfts_req_if.sink   req,
	pfts_rsp_if.source rsp
);

	localparam int LVL_W = $clog2(LEVELS);
	localparam int IDX_W = $clog2(MAX_TASKS);

	function automatic logic [ID_CNT-1:0][IDX_W-1:0] build_idx_tbl();
		logic [ID_CNT-1:0][IDX_W-1:0] tbl;
		for (int i = 0; i < ID_CNT; i++) begin
			tbl[i] = IDX_W'(i % MAX_TASKS);
		end
		return tbl;
	endfunction

	localparam logic [ID_CNT-1:0][IDX_W-1:0] IDX_TBL = build_idx_tbl();
	localparam logic signed [PRIO_W-1:0] PRIO_TOP = $signed(PRIO_W'(LEVELS - 1));

	sched_state_t state_q, state_nxt;

	logic             acc;
	logic             is_next;
	logic [IDX_W-1:0] enq_idx;
	logic [LVL_W-1:0] enq_lvl;
	logic [LVL_W-1:0] lvl;
	logic [LVL_W-1:0] lvl_s1;
	lvl_ctl_t         ctl;
	logic [IDX_W-1:0] head_wdata;
	logic [IDX_W-1:0] head_rd;
	logic [IDX_W-1:0] tail_rd;
	logic             lvl_ne;
	logic             any_ne;
	logic [LVL_W-1:0] hi_lvl;
	logic             cur_ok;
	logic             kept;
	logic             pop;
	logic             last;
	logic             ram_we;
	logic             ram_re;
	logic [IDX_W-1:0] ram_rdata;
	logic signed [PRIO_W:0] cur_prio;
	logic signed [PRIO_W:0] hi_prio;

	logic            rsp_vld_q;
	logic            next_valid_q;
	logic [ID_W-1:0] next_id_q;
	logic            kept_q;
	logic            reset_slice_q;

	assign req.ready = (state_q == ST_IDLE) && (!rsp_vld_q || rsp.ready);
	assign acc       = req.valid && req.ready;
	assign is_next   = (req.opcode == OP_GET_NEXT);
	assign enq_idx   = IDX_TBL[req.task_id];

	always_comb begin
		if (req.task_priority < 0) begin
			enq_lvl = '0;
		end else if (req.task_priority > PRIO_TOP) begin
			enq_lvl = LVL_W'(LEVELS - 1);
		end else begin
			enq_lvl = LVL_W'(req.task_priority);
		end
	end

	assign lvl = (state_q == ST_HEAD_WB) ? lvl_s1 : (is_next ? hi_lvl : enq_lvl);

	assign cur_ok   = req.current_valid && req.current_running;
	assign cur_prio = {req.current_priority[PRIO_W-1], req.current_priority};
	assign hi_prio  = $signed((PRIO_W + 1)'(hi_lvl));
	assign kept     = is_next && cur_ok && (any_ne ? (cur_prio > hi_prio) : (cur_prio > 0));
	assign pop      = is_next && !kept && any_ne;
	assign last     = (head_rd == tail_rd);

	pfts_lvl_tbl #(
		.LEVELS (LEVELS),
		.LVL_W  (LVL_W),
		.IDX_W  (IDX_W)
	) u_lvl_tbl (
		.clk        (clk),
		.arst_n     (arst_n),
		.lvl        (lvl),
		.ctl        (ctl),
		.head_wdata (head_wdata),
		.tail_wdata (enq_idx),
		.head_rd    (head_rd),
		.tail_rd    (tail_rd),
		.lvl_ne     (lvl_ne),
		.any_ne     (any_ne),
		.hi_lvl     (hi_lvl)
	);

	pfts_link_ram #(
		.DEPTH (MAX_TASKS),
		.AW    (IDX_W)
	) u_link_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (tail_rd),
		.wdata (enq_idx),
		.re    (ram_re),
		.raddr (head_rd),
		.rdata (ram_rdata)
	);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc && pop && !last) begin
					state_nxt = ST_HEAD_WB;
				end
			end
			ST_HEAD_WB: begin
				state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		ctl        = '0;
		ram_we     = 1'b0;
		ram_re     = 1'b0;
		head_wdata = enq_idx;
		case (state_q)
			ST_IDLE: begin
				if (acc && !is_next) begin
					ctl.tail_we = 1'b1;
					if (lvl_ne) begin
						ram_we = 1'b1;
					end else begin
						ctl.head_we = 1'b1;
						ctl.ne_set  = 1'b1;
					end
				end else if (acc && pop) begin
					if (last) begin
						ctl.ne_clr = 1'b1;
					end else begin
						ram_re = 1'b1;
					end
				end
			end
			ST_HEAD_WB: begin
				ctl.head_we = 1'b1;
				head_wdata  = ram_rdata;
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			lvl_s1 <= hi_lvl;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (acc) begin
			rsp_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			next_valid_q  <= kept || pop;
			kept_q        <= kept;
			reset_slice_q <= pop;
			if (kept) begin
				next_id_q <= req.current_id;
			end else if (pop) begin
				next_id_q <= ID_W'(head_rd);
			end else begin
				next_id_q <= '0;
			end
		end
	end

	assign rsp.valid        = rsp_vld_q;
	assign rsp.next_valid   = next_valid_q;
	assign rsp.next_id      = next_id_q;
	assign rsp.kept_current = kept_q;
	assign rsp.reset_slice  = reset_slice_q;

endmodule
